@@ rtl/core/tmv_pkg.sv @@
// Shared types and constants for the tridiagonal matrix-vector product block.
package tmv_pkg;

   // Fixed-point format: signed Q16.16 words.
   localparam int WORD_W = 32;
   localparam int FRAC_W = 16;

   // One row term is a coefficient times a vector element, exact in Q32.32.
   localparam int PROD_W = 2 * WORD_W;

   // Three products summed exactly need two more bits than one product.
   localparam int SUM_W = PROD_W + 2;

   // Sum after dropping the fraction bits below Q16.16.
   localparam int QUOT_W = SUM_W - FRAC_W;

   // Terms in one row of a tridiagonal matrix.
   localparam int ROW_TERMS = 3;

   // Saturation bounds.
   localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef logic signed [WORD_W-1:0] word_type;

   // One product job: three coefficient and vector element pairs.
   typedef struct packed {
      logic [ROW_TERMS-1:0][WORD_W-1:0] coef;
      logic [ROW_TERMS-1:0][WORD_W-1:0] xval;
      logic                             last;
   } job_type;

endpackage

@@ rtl/core/tmv_front.sv @@
// Front end: accepts rows, holds one row back and issues product jobs.
module tmv_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tmv_pkg::word_type req_sub_coef,
   input  tmv_pkg::word_type req_diag_coef,
   input  tmv_pkg::word_type req_super_coef,
   input  tmv_pkg::word_type req_x_value,
   input  logic             req_last_row,
   output logic             push_valid,
   output tmv_pkg::job_type push_job,
   input  logic             queue_full
);
   import tmv_pkg::*;

   // Held row and its neighbors' vector elements.
   word_type pend_sub_ff, pend_sub_in;
   word_type pend_diag_ff, pend_diag_in;
   word_type pend_super_ff, pend_super_in;
   word_type x_before_ff, x_before_in;
   word_type x_pend_ff, x_pend_in;
   logic     row_pending_ff, row_pending_in;

   // Second job of a last row that follows a held row.
   logic    extra_valid_ff, extra_valid_in;
   job_type extra_job_ff, extra_job_in;

   logic     accept;
   word_type x_above;
   job_type  held_job;
   job_type  last_job;

   // A waiting second job blocks new rows until the queue takes it.
   assign req_stall = extra_valid_ff | queue_full;
   assign accept    = req_valid & ~req_stall;
   assign x_above   = row_pending_ff ? x_pend_ff : '0;

   // Job for the held row, completed by the incoming vector element.
   always_comb begin
      held_job.coef = {pend_super_ff, pend_diag_ff, pend_sub_ff};
      held_job.xval = {req_x_value, x_pend_ff, x_before_ff};
      held_job.last = 1'b0;
      last_job.coef = {word_type'(0), req_diag_coef, req_sub_coef};
      last_job.xval = {word_type'(0), req_x_value, x_above};
      last_job.last = 1'b1;
   end

   // Job selection toward the queue.
   always_comb begin
      if (extra_valid_ff) begin
         push_valid = 1'b1;
         push_job   = extra_job_ff;
      end else begin
         push_valid = accept & (row_pending_ff | req_last_row);
         push_job   = row_pending_ff ? held_job : last_job;
      end
   end

   // Next state of the held row and the second job.
   always_comb begin
      pend_sub_in    = pend_sub_ff;
      pend_diag_in   = pend_diag_ff;
      pend_super_in  = pend_super_ff;
      x_before_in    = x_before_ff;
      x_pend_in      = x_pend_ff;
      row_pending_in = row_pending_ff;
      extra_valid_in = extra_valid_ff & queue_full;
      extra_job_in   = extra_job_ff;
      if (accept) begin
         if (req_last_row) begin
            row_pending_in = 1'b0;
            x_pend_in      = '0;
            x_before_in    = '0;
            if (row_pending_ff) begin
               extra_valid_in = 1'b1;
               extra_job_in   = last_job;
            end
         end else begin
            pend_sub_in    = req_sub_coef;
            pend_diag_in   = req_diag_coef;
            pend_super_in  = req_super_coef;
            x_before_in    = x_above;
            x_pend_in      = req_x_value;
            row_pending_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_pending_ff <= 1'b0;
         extra_valid_ff <= 1'b0;
         x_before_ff    <= '0;
         x_pend_ff      <= '0;
      end else begin
         row_pending_ff <= row_pending_in;
         extra_valid_ff <= extra_valid_in;
         x_before_ff    <= x_before_in;
         x_pend_ff      <= x_pend_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_sub_ff   <= pend_sub_in;
      pend_diag_ff  <= pend_diag_in;
      pend_super_ff <= pend_super_in;
      extra_job_ff  <= extra_job_in;
   end

   // A waiting second job must hold off the input channel.
   assert property (@(posedge clock) disable iff (reset)
      extra_valid_ff |-> req_stall)
      else $error("second job waiting while input is open");

   // A last row ends the matrix.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_last_row |=> !row_pending_ff)
      else $error("row still held after last row");

   // A last row after a held row leaves its own job for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_last_row && row_pending_ff |=> extra_valid_ff)
      else $error("second job of last row missing");

   // Any other row becomes the held row.
   assert property (@(posedge clock) disable iff (reset)
      accept && !req_last_row |=> row_pending_ff)
      else $error("row not held");

endmodule

@@ rtl/core/tmv_queue.sv @@
// Short job queue between the front end and the arithmetic back end.
module tmv_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  tmv_pkg::job_type push_job,
   output logic             queue_full,
   output logic             pop_valid,
   output tmv_pkg::job_type pop_job,
   input  logic             pop_ready
);
   import tmv_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign queue_full = (count_ff == CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & ~queue_full;
   assign do_pop     = pop_valid & pop_ready;

   // Pointer and fill count update, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Fill count stays within the depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue overfilled");

   // A push without a pop grows the count by one.
   assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

   // Pointers advance together with the count.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers out of step");

endmodule

@@ rtl/core/tmv_back.sv @@
// Back end: multiply, sum, truncate, saturate; one job per unstalled cycle.
module tmv_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  tmv_pkg::job_type  job,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tmv_pkg::word_type rsp_y_value,
   output logic              rsp_y_last,
   output logic              rsp_saturated
);
   import tmv_pkg::*;

   // Stage one: the three exact products.
   logic                                    s1_valid_ff, s1_valid_in;
   logic signed [ROW_TERMS-1:0][PROD_W-1:0] s1_prod_ff, s1_prod_in;
   logic                                    s1_last_ff;

   // Stage two: the exact row sum.
   logic                    s2_valid_ff, s2_valid_in;
   logic signed [SUM_W-1:0] s2_sum_ff, s2_sum_in;
   logic                    s2_last_ff;

   // Output register.
   logic     out_valid_ff, out_valid_in;
   word_type out_value_ff, out_value_in;
   logic     out_last_ff;
   logic     out_sat_ff, out_sat_in;

   logic                     out_en;
   logic                     s2_en;
   logic                     s1_en;
   logic signed [QUOT_W-1:0] quot;
   logic                     over;

   // Each stage loads when it is empty or its content moves on.
   assign out_en  = ~out_valid_ff | ~rsp_stall;
   assign s2_en   = ~s2_valid_ff | out_en;
   assign s1_en   = ~s1_valid_ff | s2_en;
   assign job_pop = s1_en;

   assign s1_valid_in  = s1_en ? job_valid : s1_valid_ff;
   assign s2_valid_in  = s2_en ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_en ? s2_valid_ff : out_valid_ff;

   // Independent products of each coefficient with its vector element.
   always_comb begin
      for (int k = 0; k < ROW_TERMS; k++) begin
         s1_prod_in[k] = $signed(job.coef[k]) * $signed(job.xval[k]);
      end
   end

   // Exact sum of the three products, sign extended.
   assign s2_sum_in = SUM_W'($signed(s1_prod_ff[0])) + SUM_W'($signed(s1_prod_ff[1]))
                    + SUM_W'($signed(s1_prod_ff[2]));

   // Floor to Q16.16, then clip when the upper bits are not a sign extension.
   always_comb begin
      quot = s2_sum_ff[SUM_W-1:FRAC_W];
      over = (quot[QUOT_W-1:WORD_W-1] != '0) && (quot[QUOT_W-1:WORD_W-1] != '1);
      out_sat_in = over;
      if (over) begin
         out_value_in = quot[QUOT_W-1] ? WORD_MIN : WORD_MAX;
      end else begin
         out_value_in = quot[WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers move with their stage enables.
   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_prod_ff <= s1_prod_in;
         s1_last_ff <= job.last;
      end
      if (s2_en) begin
         s2_sum_ff  <= s2_sum_in;
         s2_last_ff <= s1_last_ff;
      end
      if (out_en) begin
         out_value_ff <= out_value_in;
         out_last_ff  <= s2_last_ff;
         out_sat_ff   <= out_sat_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_y_value   = out_value_ff;
   assign rsp_y_last    = out_last_ff;
   assign rsp_saturated = out_sat_ff;

   // A full stage that cannot move keeps its valid bit.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_en |=> s1_valid_ff)
      else $error("product stage dropped a job");

   // A stalled result keeps its flags.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> $stable(out_last_ff) && $stable(out_sat_ff))
      else $error("stalled result flags changed");

   // A clipped value sits at one of the bounds.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_sat_ff |-> out_value_ff == WORD_MAX || out_value_ff == WORD_MIN)
      else $error("clipped value not at a bound");

endmodule

@@ rtl/core/tridiagonal_matrix_vector_multiply_top.sv @@
// Top level of the streaming tridiagonal matrix-vector product.
//
//   Channel   Ports                        Direction   Moves
//   req       req_valid / req_stall        in          one matrix row with its x element
//   rsp       rsp_valid / rsp_stall        out         one element of y = A*x
//
// A row is accepted every cycle while the job queue is not full; a last row that
// follows a held row blocks the next row, as the front end issues two product jobs
// for it, one per cycle while the queue is not full. A job passes the multiply,
// sum and saturate registers, and a row's result waits for the next row's x element.
// Reset clears the held row, the job queue and the back-end pipeline.
// The job queue of QUEUE_DEPTH entries lets the front end keep taking rows
// while the result side stalls, until the queue fills.
module tridiagonal_matrix_vector_multiply_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tmv_pkg::word_type req_sub_coef,
   input  tmv_pkg::word_type req_diag_coef,
   input  tmv_pkg::word_type req_super_coef,
   input  tmv_pkg::word_type req_x_value,
   input  logic              req_last_row,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tmv_pkg::word_type rsp_y_value,
   output logic              rsp_y_last,
   output logic              rsp_saturated
);
   import tmv_pkg::*;

   logic    push_valid;
   job_type push_job;
   logic    queue_full;
   logic    pop_valid;
   job_type pop_job;
   logic    pop_ready;

   // Row intake and job issue.
   tmv_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sub_coef   (req_sub_coef),
      .req_diag_coef  (req_diag_coef),
      .req_super_coef (req_super_coef),
      .req_x_value    (req_x_value),
      .req_last_row   (req_last_row),
      .push_valid     (push_valid),
      .push_job       (push_job),
      .queue_full     (queue_full)
   );

   // Decoupling queue.
   tmv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .queue_full (queue_full),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   // Arithmetic pipeline and result register.
   tmv_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (pop_valid),
      .job           (pop_job),
      .job_pop       (pop_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_y_value   (rsp_y_value),
      .rsp_y_last    (rsp_y_last),
      .rsp_saturated (rsp_saturated)
   );

endmodule

@@ tb/sv/tridiagonal_matrix_vector_multiply_top_test.sv @@
// Self-checking testbench for the streaming tridiagonal matrix-vector product block.
module tridiagonal_matrix_vector_multiply_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tmv_pkg::*;

   localparam int DIR_ROWS      = 19;
   localparam int RANDOM_ROWS   = 1400;
   localparam int MAX_REPORTS   = 10;
   localparam int HOLD_AT       = 300;
   localparam int HOLD_CYCLES   = 200;
   localparam int TAIL_CYCLES   = 16;
   localparam int IDLE_LIMIT    = 2000;
   localparam longint Y_HI      = 64'sd2147483647;
   localparam longint Y_LO      = -64'sd2147483648;

   // One matrix row as driven, with an optional hand-written expectation.
   typedef struct packed {
      word_type sub;
      word_type diag;
      word_type sup;
      word_type x;
      logic     last;
      logic     typed;
      word_type ty;
      logic     tsat;
   } matrix_row_type;

   // One element of y = A*x.
   typedef struct packed {
      word_type y;
      logic     last;
      logic     sat;
   } y_elem_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   word_type          req_sub_coef;
   word_type          req_diag_coef;
   word_type          req_super_coef;
   word_type          req_x_value;
   logic              req_last_row;
   logic              rsp_valid;
   logic              rsp_stall;
   word_type          rsp_y_value;
   logic              rsp_y_last;
   logic              rsp_saturated;

   // Held-row copy of the block's state.
   word_type          held_sub;
   word_type          held_diag;
   word_type          held_super;
   word_type          x_above_held;
   word_type          x_held;
   logic              row_held;

   y_elem_type        expected_y_q[$];
   matrix_row_type    cur_row;
   int                error_count = 0;
   int                rows_sent;
   int                rows_accepted = 0;
   int                matrices_seen = 0;
   int                elems_checked = 0;
   int                sat_seen = 0;
   int                input_stall_cycles = 0;
   int                idle_cycles = 0;

   // Single-row matrices are typed in; the rest go through the predictor.
   matrix_row_type dir_rows [DIR_ROWS] = '{
      '{32'h7FFFFFFF, 32'h00010000, 32'h7FFFFFFF, 32'h00030000, 1'b1, 1'b1, 32'h00030000, 1'b0},
      '{32'h00000000, 32'h80000000, 32'h00000000, 32'h80000000, 1'b1, 1'b1, 32'h7FFFFFFF, 1'b1},
      '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 1'b1, 1'b1, 32'h80000000, 1'b1},
      '{32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b0},
      '{32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 1'b1, 1'b1, 32'h00000000, 1'b0},
      '{32'h80000000, 32'h00010000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b1, 32'h7FFFFFFF, 1'b0},
      '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 1'b1, 32'h00000000, 1'b0},
      '{32'h00000000, 32'hFFFF0000, 32'h00000000, 32'h80000000, 1'b1, 1'b1, 32'h7FFFFFFF, 1'b1},
      '{32'h00000000, 32'hFFFF0000, 32'h00000000, 32'h7FFFFFFF, 1'b1, 1'b1, 32'h80000001, 1'b0},
      '{32'h80000000, 32'h00020000, 32'h00010000, 32'h00010000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'hFFFF0000, 32'h00030000, 32'h00008000, 32'hFFFE0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h00010000, 32'h00010000, 32'h7FFFFFFF, 32'h00040000, 1'b1, 1'b0, 32'h0, 1'b0},
      '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b0, 32'h0, 1'b0},
      '{32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h80000000, 32'h7FFFFFFF, 32'h00000000, 32'h80000000, 1'b1, 1'b0, 32'h0, 1'b0},
      '{32'h12345678, 32'h00010000, 32'h00010000, 32'h00010000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h00010000, 32'h00010000, 32'h00000000, 32'h00010000, 1'b1, 1'b0, 32'h0, 1'b0}
   };

   tridiagonal_matrix_vector_multiply_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sub_coef   (req_sub_coef),
      .req_diag_coef  (req_diag_coef),
      .req_super_coef (req_super_coef),
      .req_x_value    (req_x_value),
      .req_last_row   (req_last_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_y_value    (rsp_y_value),
      .rsp_y_last     (rsp_y_last),
      .rsp_saturated  (rsp_saturated)
   );

   // Clock generation.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Wait drawn per item, with stretches of back-to-back traffic.
   function automatic int pick_wait(input int n);
      if ((n / 40) % 3 == 2) return 0;
      return $urandom_range(0, 14);
   endfunction

   // Field value mixing extremes, unity, small numbers and full-range words.
   function automatic word_type draw_word();
      case ($urandom_range(0, 9))
         0: return 32'h80000000;
         1: return 32'h7FFFFFFF;
         2: return 32'h00000000;
         3: return ($urandom_range(0, 1) != 0) ? 32'h00010000 : 32'hFFFF0000;
         4, 5: return word_type'($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
         default: return word_type'($urandom);
      endcase
   endfunction

   // Sums three exact products, floors to Q16.16 and saturates.
   function automatic y_elem_type row_product(input word_type c0, x0, c1, x1, c2, x2,
                                              input logic last);
      logic signed [SUM_W-1:0] acc;
      longint q;
      y_elem_type e;
      acc = c0 * x0 + c1 * x1 + c2 * x2;
      q = longint'(acc >>> FRAC_W);
      e.last = last;
      e.sat = 1'b0;
      if (q > Y_HI) begin
         e.y = WORD_MAX;
         e.sat = 1'b1;
      end else if (q < Y_LO) begin
         e.y = WORD_MIN;
         e.sat = 1'b1;
      end else begin
         e.y = q[WORD_W-1:0];
      end
      return e;
   endfunction

   function automatic void clear_held();
      held_sub = '0;
      held_diag = '0;
      held_super = '0;
      x_above_held = '0;
      x_held = '0;
      row_held = 1'b0;
   endfunction

   // A new row completes the held row; a last row also yields its own element.
   function automatic void predict_row(input word_type sub, diag, sup, x, input logic last);
      word_type x_up;
      x_up = '0;
      if (row_held) begin
         expected_y_q.push_back(row_product(held_sub, x_above_held, held_diag, x_held,
                                            held_super, x, 1'b0));
         x_up = x_held;
      end
      if (last) begin
         expected_y_q.push_back(row_product(sub, x_up, diag, x, '0, '0, 1'b1));
         clear_held();
      end else begin
         held_sub = sub;
         held_diag = diag;
         held_super = sup;
         x_above_held = x_up;
         x_held = x;
         row_held = 1'b1;
      end
   endfunction

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
   endfunction

   // Offers one row after its drawn wait and holds it until accepted.
   task automatic send_row(input matrix_row_type r);
      int gap;
      gap = pick_wait(rows_sent);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_sub_coef   <= r.sub;
      req_diag_coef  <= r.diag;
      req_super_coef <= r.sup;
      req_x_value    <= r.x;
      req_last_row   <= r.last;
      cur_row        <= r;
      do @(posedge clock); while (!(req_valid && !req_stall));
      rows_sent++;
   endtask

   // Predict on each accepted row, check each accepted result.
   always @(posedge clock) begin : scoreboard
      y_elem_type want;
      if (reset) begin
         clear_held();
      end else begin
         if (req_valid && !req_stall) begin
            predict_row(req_sub_coef, req_diag_coef, req_super_coef, req_x_value,
                        req_last_row);
            if (cur_row.typed) begin
               void'(expected_y_q.pop_back());
               expected_y_q.push_back('{cur_row.ty, 1'b1, cur_row.tsat});
            end
            rows_accepted++;
            if (req_last_row) matrices_seen++;
         end
         if (req_valid && req_stall) input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (rsp_saturated) sat_seen++;
            if (expected_y_q.size() == 0) begin
               flag_error($sformatf("unexpected item y=%h last=%b sat=%b",
                                    rsp_y_value, rsp_y_last, rsp_saturated));
            end else begin
               want = expected_y_q.pop_front();
               elems_checked++;
               if (rsp_y_value !== want.y || rsp_y_last !== want.last ||
                   rsp_saturated !== want.sat)
                  flag_error($sformatf({"mismatch: expected y=%h last=%b sat=%b,",
                                        " got y=%h last=%b sat=%b"},
                                       want.y, want.last, want.sat,
                                       rsp_y_value, rsp_y_last, rsp_saturated));
            end
         end
      end
   end

   // Watchdog on cycles without any accepted item.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: random stalls, and one long hold-off to fill the block.
   initial begin : result_sink
      int gap;
      int taken;
      taken = 0;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = (taken == HOLD_AT) ? HOLD_CYCLES : pick_wait(taken);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         taken++;
      end
   end

   // Reset, directed rows, random matrices, drain and verdict.
   initial begin : row_source
      matrix_row_type r;
      int len;
      int k;
      rows_sent = 0;
      cur_row = '0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_sub_coef   <= '0;
      req_diag_coef  <= '0;
      req_super_coef <= '0;
      req_x_value    <= '0;
      req_last_row   <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < DIR_ROWS; k++) send_row(dir_rows[k]);

      // Whole matrices of random length, mostly short, a few long.
      while (rows_sent < DIR_ROWS + RANDOM_ROWS) begin
         case ($urandom_range(0, 19))
            0, 1, 2: len = 1;
            3:       len = $urandom_range(9, 24);
            default: len = $urandom_range(2, 8);
         endcase
         for (k = 0; k < len; k++) begin
            r = '0;
            r.sub  = draw_word();
            r.diag = draw_word();
            r.sup  = draw_word();
            r.x    = draw_word();
            r.last = (k == len - 1);
            send_row(r);
         end
      end
      req_valid <= 1'b0;

      while (expected_y_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d rows in %0d matrices; %0d product elements checked, %0d saturated.",
               rows_accepted, matrices_seen, elems_checked, sat_seen);
      $display("Input was held off by back-pressure for %0d cycles; %0d errors found.",
               input_stall_cycles, error_count);
      if (error_count == 0 && expected_y_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
